// ===== rtl/core/flla_pkg.sv =====
// Shared types and constants of the FIFO lease lock arbiter.
package flla_pkg;

  localparam logic [31:0] HOLDER_STALE_RESET = 32'd300000;
  localparam logic [31:0] WAITER_STALE_RESET = 32'd60000;

  localparam logic [2:0] REQ_ACQUIRE     = 3'd0;
  localparam logic [2:0] REQ_RELEASE     = 3'd1;
  localparam logic [2:0] REQ_RELEASE_ANY = 3'd2;
  localparam logic [2:0] REQ_CANCEL      = 3'd3;
  localparam logic [2:0] REQ_SWEEP       = 3'd4;
  localparam logic [2:0] REQ_CLEAR       = 3'd5;

  localparam logic [3:0] ST_READ_BYPASS  = 4'd0;
  localparam logic [3:0] ST_MISSING_ID   = 4'd1;
  localparam logic [3:0] ST_ALREADY      = 4'd2;
  localparam logic [3:0] ST_ACQUIRED     = 4'd3;
  localparam logic [3:0] ST_ACQ_SWEPT    = 4'd4;
  localparam logic [3:0] ST_QUEUED       = 4'd5;
  localparam logic [3:0] ST_QUEUE_FULL   = 4'd6;
  localparam logic [3:0] ST_RELEASED     = 4'd7;
  localparam logic [3:0] ST_NOT_OWNER    = 4'd8;
  localparam logic [3:0] ST_CANCELLED    = 4'd9;
  localparam logic [3:0] ST_NOT_WAITING  = 4'd10;
  localparam logic [3:0] ST_CLEARED      = 4'd11;
  localparam logic [3:0] ST_QUERY_DONE   = 4'd12;

  localparam logic CFG_HOLDER_STALE = 1'b0;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  domain;
    logic [15:0] client_id;
    logic        read_tier;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        granted;
    logic        waiting;
    logic        swept_any;
    logic        holder_dropped;
    logic [3:0]  waiters_dropped;
    logic [15:0] job_tag;
    logic        domain_busy;
    logic        any_busy;
    logic [3:0]  pending;
    logic [15:0] holder_id;
  } rsp_t;

  typedef struct packed {
    logic        index;
    logic [31:0] data;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ident;
    logic [31:0] seen;
    logic [15:0] tag;
  } entry_t;

endpackage

// ===== rtl/core/flla_if.sv =====
// Valid/ready channel interface used for requests, responses and configuration.
interface flla_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/fifo_lease_lock_arbiter.sv =====
// Top level of the FIFO lease lock arbiter: sequencer, holder slots and waiter RAM.
//
//  channel  dir  handshake        payload
//  req_i    in   valid / ready    req_type, domain, client_id, read_tier, now
//  rsp_o    out  valid / ready    status, flags, counts, job_tag, holder_id
//  cfg_i    in   valid / ready    index (0 holder, 1 waiter stale ticks), data
//
// A release, force clear, query or read-tier acquire touches no waiter RAM; a sweep
// or cancel compacts the domain's waiters once and an acquire up to twice. The waiter
// RAM port, which moves one entry per cycle during compaction, paces that work.
// Release in any domain walks the domains one per cycle. Reset empties all
// holders and FIFOs at once. A stalled response holds in the output register
// and the next request is taken meanwhile.
module fifo_lease_lock_arbiter #(
  parameter int NUM_DOMAINS = 4,
  parameter int FIFO_DEPTH  = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  flla_stream_if.sink   req_i,
  flla_stream_if.source rsp_o,
  flla_stream_if.sink   cfg_i
);
  import flla_pkg::*;

  localparam int DW   = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
  localparam int CW   = $clog2(FIFO_DEPTH + 1);
  localparam int RAMD = NUM_DOMAINS * FIFO_DEPTH;
  localparam int AW   = (RAMD > 1) ? $clog2(RAMD) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_PASS   = 3'd2;
  localparam logic [2:0] S_ACQ    = 3'd3;
  localparam logic [2:0] S_RELANY = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam logic [1:0] M_SWEEP  = 2'd0;
  localparam logic [1:0] M_CANCEL = 2'd1;
  localparam logic [1:0] M_HEAD   = 2'd2;

  function automatic logic [DW-1:0] to_dom(logic [1:0] raw);
    int v;
    v = int'(raw);
    for (int k = 0; k < 4; k++) begin
      if (v >= NUM_DOMAINS) v = v - NUM_DOMAINS;
    end
    return DW'(v);
  endfunction

  function automatic logic [AW-1:0] ent_addr(logic [DW-1:0] d, logic [CW-1:0] s);
    return AW'(int'(d) * FIFO_DEPTH + int'(s));
  endfunction

  logic [2:0]  state_q, state_d;
  logic [2:0]  ty_q, ty_d;
  logic [DW-1:0] d_q, d_d;
  logic [15:0] id_q, id_d;
  logic        rt_q, rt_d;
  logic [31:0] now_q, now_d;
  logic [31:0] hst_q, hst_d, wst_q, wst_d;
  logic [15:0] holder_q [NUM_DOMAINS];
  logic [15:0] holder_d [NUM_DOMAINS];
  logic [31:0] htime_q [NUM_DOMAINS];
  logic [31:0] htime_d [NUM_DOMAINS];
  logic [CW-1:0] cnt_q [NUM_DOMAINS];
  logic [CW-1:0] cnt_d [NUM_DOMAINS];
  logic [15:0] tag_q, tag_d;
  logic [1:0]  mode_q, mode_d;
  logic [CW-1:0] rd_q, rd_d, wr_q, wr_d, pidx_q, pidx_d, pos_q, pos_d, dcnt_q, dcnt_d;
  logic        pv_q, pv_d, found_q, found_d;
  logic [15:0] ptag_q, ptag_d;
  logic [3:0]  status_q, status_d;
  logic        granted_q, granted_d, waiting_q, waiting_d, hd_q, hd_d;
  logic [CW-1:0] wdrop_q, wdrop_d;
  logic [15:0] jtag_q, jtag_d;
  logic [DW-1:0] ri_q, ri_d;
  rsp_t        out_q, out_d;
  logic        ovalid_q, ovalid_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  flla_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(RAMD)
  ) u_flla_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = ovalid_q;
  assign rsp_o.data  = out_q;

  logic [15:0]   cur_hold;
  logic [CW-1:0] cur_cnt;
  logic          any_hold;
  logic          drop;
  logic          ok;
  logic [CW-1:0] p;
  logic [15:0]   t;

  assign cur_hold = holder_q[d_q];
  assign cur_cnt  = cnt_q[d_q];

  always_comb begin
    any_hold = 1'b0;
    for (int k = 0; k < NUM_DOMAINS; k++) begin
      if (holder_q[k] != 16'd0) any_hold = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q; ty_d = ty_q; d_d = d_q; id_d = id_q; rt_d = rt_q; now_d = now_q;
    hst_d = hst_q; wst_d = wst_q;
    holder_d = holder_q; htime_d = htime_q; cnt_d = cnt_q; tag_d = tag_q;
    mode_d = mode_q; rd_d = rd_q; wr_d = wr_q; pidx_d = pidx_q; pos_d = pos_q;
    dcnt_d = dcnt_q; pv_d = pv_q; found_d = found_q; ptag_d = ptag_q;
    status_d = status_q; granted_d = granted_q; waiting_d = waiting_q; hd_d = hd_q;
    wdrop_d = wdrop_q; jtag_d = jtag_q; ri_d = ri_q;
    out_d = out_q; ovalid_d = ovalid_q;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;
    drop = 1'b0; ok = 1'b0; p = '0; t = '0;

    if (cfg_i.valid) begin
      if (cfg_i.data.index == CFG_HOLDER_STALE) hst_d = cfg_i.data.data;
      else wst_d = cfg_i.data.data;
    end

    if (ovalid_q && rsp_o.ready) ovalid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          ty_d = req_i.data.req_type;
          d_d = to_dom(req_i.data.domain);
          id_d = req_i.data.client_id;
          rt_d = req_i.data.read_tier;
          now_d = req_i.data.now;
          status_d = ST_QUERY_DONE;
          granted_d = 1'b0; waiting_d = 1'b0; hd_d = 1'b0;
          wdrop_d = '0; jtag_d = '0;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        rd_d = '0; wr_d = '0; pv_d = 1'b0; dcnt_d = '0; found_d = 1'b0; pos_d = '0;
        state_d = S_FIN;
        if (ty_q inside {REQ_ACQUIRE, REQ_RELEASE, REQ_RELEASE_ANY, REQ_CANCEL}
            && !(ty_q == REQ_ACQUIRE && rt_q) && id_q == 16'd0) begin
          status_d = ST_MISSING_ID;
        end else begin
          case (ty_q)
            REQ_ACQUIRE, REQ_SWEEP: begin
              if (ty_q == REQ_ACQUIRE && rt_q) begin
                status_d = ST_READ_BYPASS;
                granted_d = 1'b1;
              end else begin
                // The holder ages out first; the waiters follow in the pass.
                if (cur_hold != 16'd0 && (now_q - htime_q[d_q]) > hst_q) begin
                  holder_d[d_q] = '0;
                  htime_d[d_q] = '0;
                  hd_d = 1'b1;
                end
                if (ty_q == REQ_SWEEP) status_d = ST_CLEARED;
                mode_d = M_SWEEP;
                state_d = S_PASS;
              end
            end
            REQ_RELEASE: begin
              if (cur_hold == id_q) begin
                holder_d[d_q] = '0;
                htime_d[d_q] = '0;
                status_d = ST_RELEASED;
              end else begin
                status_d = ST_NOT_OWNER;
              end
            end
            REQ_RELEASE_ANY: begin
              ri_d = '0;
              state_d = S_RELANY;
            end
            REQ_CANCEL: begin
              mode_d = M_CANCEL;
              state_d = S_PASS;
            end
            REQ_CLEAR: begin
              holder_d[d_q] = '0;
              htime_d[d_q] = '0;
              cnt_d[d_q] = '0;
              status_d = ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_PASS: begin
        // Compaction: read entry rd while entry rd-1 is kept or dropped.
        if (rd_q < cur_cnt) begin
          ram_raddr = ent_addr(d_q, rd_q);
          rd_d = rd_q + 1'b1;
          pidx_d = rd_q;
          pv_d = 1'b1;
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          case (mode_q)
            M_SWEEP:  drop = (now_q - ram_rdata.seen) > wst_q;
            M_CANCEL: drop = (ram_rdata.ident == id_q);
            M_HEAD:   drop = (pidx_q == '0);
            default:  drop = 1'b0;
          endcase
          if (drop) begin
            dcnt_d = dcnt_q + 1'b1;
          end else begin
            ram_we = 1'b1;
            ram_waddr = ent_addr(d_q, wr_q);
            ram_wdata = ram_rdata;
            wr_d = wr_q + 1'b1;
            if (mode_q == M_SWEEP && !found_q && ram_rdata.ident == id_q) begin
              found_d = 1'b1;
              pos_d = wr_q;
              ptag_d = ram_rdata.tag;
            end
          end
        end
        if (!pv_q && rd_q >= cur_cnt) begin
          cnt_d[d_q] = wr_q;
          state_d = S_FIN;
          case (mode_q)
            M_SWEEP: begin
              wdrop_d = dcnt_q;
              if (ty_q == REQ_ACQUIRE) state_d = S_ACQ;
            end
            M_CANCEL: status_d = (dcnt_q != '0) ? ST_CANCELLED : ST_NOT_WAITING;
            default: ;
          endcase
        end
      end
      S_ACQ: begin
        state_d = S_FIN;
        if (cur_hold == id_q) begin
          htime_d[d_q] = now_q;
          status_d = ST_ALREADY;
          granted_d = 1'b1;
        end else begin
          ok = 1'b1;
          p = pos_q;
          t = ptag_q;
          if (found_q) begin
            ram_we = 1'b1;
            ram_waddr = ent_addr(d_q, pos_q);
            ram_wdata = '{ident: id_q, seen: now_q, tag: ptag_q};
          end else if (cur_cnt >= CW'(FIFO_DEPTH)) begin
            ok = 1'b0;
            status_d = ST_QUEUE_FULL;
          end else begin
            ram_we = 1'b1;
            ram_waddr = ent_addr(d_q, cur_cnt);
            ram_wdata = '{ident: id_q, seen: now_q, tag: tag_q};
            tag_d = tag_q + 16'd1;
            cnt_d[d_q] = cur_cnt + 1'b1;
            p = cur_cnt;
            t = tag_q;
          end
          if (ok) begin
            if (cur_hold == 16'd0 && p == '0) begin
              holder_d[d_q] = id_q;
              htime_d[d_q] = now_q;
              status_d = (hd_q || wdrop_q != '0) ? ST_ACQ_SWEPT : ST_ACQUIRED;
              granted_d = 1'b1;
              rd_d = '0; wr_d = '0; pv_d = 1'b0; dcnt_d = '0;
              mode_d = M_HEAD;
              state_d = S_PASS;
            end else begin
              status_d = ST_QUEUED;
              waiting_d = 1'b1;
              jtag_d = t;
            end
          end
        end
      end
      S_RELANY: begin
        if (holder_q[ri_q] == id_q) begin
          holder_d[ri_q] = '0;
          htime_d[ri_q] = '0;
          status_d = ST_RELEASED;
          state_d = S_FIN;
        end else if (ri_q == DW'(NUM_DOMAINS - 1)) begin
          status_d = ST_NOT_OWNER;
          state_d = S_FIN;
        end else begin
          ri_d = ri_q + 1'b1;
        end
      end
      S_FIN: begin
        if (!ovalid_q || rsp_o.ready) begin
          out_d.status = status_q;
          out_d.granted = granted_q;
          out_d.waiting = waiting_q;
          out_d.swept_any = hd_q || (wdrop_q != '0);
          out_d.holder_dropped = hd_q;
          out_d.waiters_dropped = 4'(wdrop_q);
          out_d.job_tag = jtag_q;
          out_d.domain_busy = (cur_hold != 16'd0);
          out_d.any_busy = any_hold;
          out_d.pending = 4'(cur_cnt);
          out_d.holder_id = cur_hold;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hst_q <= HOLDER_STALE_RESET;
      wst_q <= WAITER_STALE_RESET;
      for (int k = 0; k < NUM_DOMAINS; k++) begin
        holder_q[k] <= '0;
        htime_q[k] <= '0;
        cnt_q[k] <= '0;
      end
      tag_q <= '0;
      pv_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hst_q <= hst_d;
      wst_q <= wst_d;
      holder_q <= holder_d;
      htime_q <= htime_d;
      cnt_q <= cnt_d;
      tag_q <= tag_d;
      pv_q <= pv_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ty_q <= ty_d; d_q <= d_d; id_q <= id_d; rt_q <= rt_d; now_q <= now_d;
    mode_q <= mode_d; rd_q <= rd_d; wr_q <= wr_d; pidx_q <= pidx_d; pos_q <= pos_d;
    dcnt_q <= dcnt_d; found_q <= found_d; ptag_q <= ptag_d;
    status_q <= status_d; granted_q <= granted_d; waiting_q <= waiting_d; hd_q <= hd_d;
    wdrop_q <= wdrop_d; jtag_q <= jtag_d; ri_q <= ri_d;
    out_q <= out_d;
  end
endmodule

// ===== rtl/core/flla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module flla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/flla_checker.sv =====
// Port-level checks of the FIFO lease lock arbiter and their bind.
module flla_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input flla_pkg::rsp_t  rsp_data_i
);
  import flla_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous one is still in work");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("stalled response changed");

  a_busy_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.domain_busy |-> rsp_data_i.any_busy)
    else $error("domain busy without any domain busy");

  a_grant_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.granted |->
      (rsp_data_i.status == ST_READ_BYPASS || rsp_data_i.status == ST_ALREADY ||
       rsp_data_i.status == ST_ACQUIRED || rsp_data_i.status == ST_ACQ_SWEPT) &&
      !rsp_data_i.waiting)
    else $error("grant with a non-grant status");

  a_queued_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.status == ST_QUEUED |->
      rsp_data_i.waiting && rsp_data_i.pending != 4'd0)
    else $error("queued response without a waiting entry");
endmodule

bind fifo_lease_lock_arbiter flla_checker u_flla_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_i.valid),
  .req_ready_i(req_i.ready),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .rsp_data_i (rsp_o.data)
);
